@@ design/pnsf_pkg.sv @@
package pnsf_pkg;

  localparam int WHITE_BITS = 15;
  localparam int AMP_W      = 17;
  localparam int COEF_W     = 18;
  localparam int STATE_W    = 32;
  localparam int PROD_W     = STATE_W + COEF_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int COEF_SHIFT = 17;
  localparam int SH_W       = ACC_W - COEF_SHIFT;
  localparam int SUM_W      = 36;
  localparam int Q_W        = SUM_W - 8;
  localparam int OUT_W      = 16;
  localparam int NPOLES     = 6;
  localparam int IDX_W      = $clog2(NPOLES);
  localparam int AMP_SHIFT  = 10;

  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);

  localparam logic signed [COEF_W-1:0] DIRECT_GAIN = COEF_W'(70281);
  localparam logic signed [COEF_W-1:0] DELAY_GAIN  = COEF_W'(15195);

  typedef logic [2:0] op_t;
  localparam op_t OP_NONE   = 3'd0;
  localparam op_t OP_AMP    = 3'd1;
  localparam op_t OP_FB     = 3'd2;
  localparam op_t OP_IN     = 3'd3;
  localparam op_t OP_DIRECT = 3'd4;
  localparam op_t OP_DELAY  = 3'd5;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             fin;
  } ctl_t;

  function automatic logic signed [COEF_W-1:0] fb_coef(input logic [IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    unique case (idx)
      3'd0:    c = COEF_W'(130923);
      3'd1:    c = COEF_W'(130196);
      3'd2:    c = COEF_W'(127009);
      3'd3:    c = COEF_W'(113574);
      3'd4:    c = COEF_W'(72090);
      3'd5:    c = -COEF_W'(99824);
      default: c = '0;
    endcase
    return c;
  endfunction

  // last pole takes its input term negated
  function automatic logic signed [COEF_W-1:0] in_coef(input logic [IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    unique case (idx)
      3'd0:    c = COEF_W'(7277);
      3'd1:    c = COEF_W'(9840);
      3'd2:    c = COEF_W'(20166);
      3'd3:    c = COEF_W'(40696);
      3'd4:    c = COEF_W'(69855);
      3'd5:    c = -COEF_W'(2215);
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SH_W-1:0] v);
    logic signed [STATE_W-1:0] r;
    if (v[SH_W-1:STATE_W-1] == '0 || v[SH_W-1:STATE_W-1] == '1) begin
      r = v[STATE_W-1:0];
    end else if (v[SH_W-1]) begin
      r = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(STATE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ design/pnsf_in_if.sv @@
interface pnsf_in_if import pnsf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [WHITE_BITS-1:0] white_sample;

  modport source (output valid, output white_sample, input ready);
  modport sink   (input valid, input white_sample, output ready);
endinterface

@@ design/pnsf_out_if.sv @@
interface pnsf_out_if import pnsf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pink_sample;
  logic                    clipped;

  modport source (output valid, output pink_sample, output clipped, input ready);
  modport sink   (input valid, input pink_sample, input clipped, output ready);
endinterface

@@ design/pink_noise_shaping_filter.sv @@
// pink noise shaping filter
// in_chan carries one unsigned white noise sample per transaction; out_chan
// returns one saturated signed 16-bit pink sample with a clipped flag per
// input. cfg_wr_en/cfg_wr_data load the 17-bit amplitude (q16, values above
// 1.0 act as 1.0); write it only while the block is idle.
// a single 32x18 multiplier is shared by all 15 products of a sample (gain,
// six poles with feedback and input terms, direct and delayed terms) under
// a 16-step counter; the finish step then loads the output register, and
// the block returns to idle to take the next sample, so it takes no new
// sample before it is through with the last one.
// in_chan.ready is high only while idle; a new sample may be taken while a
// finished result still waits in the output register. if the receiver stalls
// and the next result is finished, the block holds it in the finish step
// until the output register frees up.
// reset clears the pole and delay state, sets amplitude to 1.0 and empties
// the output register.
module pink_noise_shaping_filter import pnsf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  pnsf_in_if.sink          in_chan,
  pnsf_out_if.source       out_chan,
  input  logic             cfg_wr_en,
  input  logic [AMP_W-1:0] cfg_wr_data
);

  logic [AMP_W-1:0]        amp_r;
  logic [AMP_W-1:0]        amp_eff;
  logic [WHITE_BITS-1:0]   white_r;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] pink_r;
  logic                    clip_r;
  logic signed [OUT_W-1:0] pink;
  logic                    clip;
  logic                    out_free;
  logic                    in_accept;
  ctl_t                    ctl;

  assign out_free  = !out_valid_r || out_chan.ready;
  assign in_accept = in_chan.valid && in_chan.ready;
  assign amp_eff   = (amp_r > AMP_ONE) ? AMP_ONE : amp_r;

  pnsf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .out_free (out_free),
    .ctl      (ctl)
  );

  pnsf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .white (white_r),
    .amp   (amp_eff),
    .pink  (pink),
    .clip  (clip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r       <= AMP_ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) amp_r <= cfg_wr_data;
      if (ctl.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) white_r <= in_chan.white_sample;
    if (ctl.fin) begin
      pink_r <= pink;
      clip_r <= clip;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pink_sample = pink_r;
  assign out_chan.clipped     = clip_r;

  as_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_chan.ready)
    else $error("input taken while a sample is in progress");

  as_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && clip_r) |->
      (pink_r == {1'b0, {(OUT_W-1){1'b1}}} || pink_r == {1'b1, {(OUT_W-1){1'b0}}}))
    else $error("clip flag set on an unsaturated sample");

  as_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fin |-> out_free)
    else $error("result loaded over an untaken result");

endmodule

@@ design/pnsf_seq.sv @@
module pnsf_seq import pnsf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_free,
  output ctl_t ctl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [3:0] step_m1;

  assign in_ready = (state_r == ST_IDLE);
  assign step_m1  = step_r - 4'd1;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctl.op    = OP_NONE;
    ctl.idx   = IDX_W'(step_m1 >> 1);
    ctl.fin   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        priority if (step_r == 4'd0) begin
          ctl.op = OP_AMP;
        end else if (step_r <= 4'd12) begin
          ctl.op = step_r[0] ? OP_FB : OP_IN;
        end else if (step_r == 4'd13) begin
          ctl.op = OP_DIRECT;
        end else if (step_r == 4'd14) begin
          ctl.op = OP_DELAY;
        end else begin
          ctl.op = OP_NONE;
        end
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd15) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        ctl.fin = out_free;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  as_run_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && step_r == 4'd15) |=> (state_r == ST_FIN))
    else $error("sequencer did not reach finish after last step");

endmodule

@@ design/pnsf_mac.sv @@
module pnsf_mac import pnsf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctl_t                    ctl,
  input  logic [WHITE_BITS-1:0]   white,
  input  logic [AMP_W-1:0]        amp,
  output logic signed [OUT_W-1:0] pink,
  output logic                    clip
);

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (COEF_SHIFT - 1);

  logic signed [STATE_W-1:0] pole_r [NPOLES];
  logic signed [STATE_W-1:0] delayed_r;
  logic signed [STATE_W-1:0] w_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [SH_W-1:0]    res_r;
  logic                      res_pend_r;
  logic signed [SUM_W-1:0]   p_r;
  op_t                       op_r;
  logic [IDX_W-1:0]          idx_r;

  logic signed [STATE_W-1:0]           mul_a;
  logic signed [COEF_W-1:0]            mul_b;
  logic signed [PROD_W-1:0]            prod_nxt;
  logic signed [ACC_W-1:0]             sum_in;
  logic signed [ACC_W-1:0]             sum_dir;
  logic signed [SH_W-1:0]              sh_in;
  logic signed [SH_W-1:0]              sh_dir;
  logic [PROD_W-1:0]                   w_rnd;
  logic [PROD_W-AMP_SHIFT-1:0]         w_sh;
  logic signed [STATE_W-1:0]           w_sat;
  logic signed [SUM_W-1:0]             p_bias;
  logic signed [Q_W-1:0]               q;

  // shared multiplier operand select
  always_comb begin
    unique case (ctl.op)
      OP_AMP: begin
        mul_a = STATE_W'(white);
        mul_b = COEF_W'(amp);
      end
      OP_FB: begin
        mul_a = pole_r[ctl.idx];
        mul_b = fb_coef(ctl.idx);
      end
      OP_IN: begin
        mul_a = w_r;
        mul_b = in_coef(ctl.idx);
      end
      OP_DIRECT: begin
        mul_a = w_r;
        mul_b = DIRECT_GAIN;
      end
      OP_DELAY: begin
        mul_a = w_r;
        mul_b = DELAY_GAIN;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign w_rnd = prod_r + PROD_W'(1 << (AMP_SHIFT - 1));
  assign w_sh  = w_rnd[PROD_W-1:AMP_SHIFT];
  assign w_sat = (|w_sh[PROD_W-AMP_SHIFT-1:STATE_W-1]) ? {1'b0, {(STATE_W-1){1'b1}}}
                                                       : w_sh[STATE_W-1:0];

  assign sum_in  = acc_r + ACC_W'(prod_r);
  assign sum_dir = ACC_W'(prod_r) + HALF_LSB;
  assign sh_in   = sum_in[ACC_W-1:COEF_SHIFT];
  assign sh_dir  = sum_dir[ACC_W-1:COEF_SHIFT];

  // truncation toward zero, then saturation to the sample width
  assign p_bias = p_r + (p_r[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
  assign q      = p_bias[SUM_W-1:8];

  always_comb begin
    if (q > Q_W'(32767)) begin
      pink = {1'b0, {(OUT_W-1){1'b1}}};
      clip = 1'b1;
    end else if (q < -Q_W'(32768)) begin
      pink = {1'b1, {(OUT_W-1){1'b0}}};
      clip = 1'b1;
    end else begin
      pink = q[OUT_W-1:0];
      clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r       <= OP_NONE;
      res_pend_r <= 1'b0;
      delayed_r  <= '0;
      for (int i = 0; i < NPOLES; i++) pole_r[i] <= '0;
    end else begin
      op_r       <= ctl.op;
      res_pend_r <= (op_r == OP_IN) || (op_r == OP_DIRECT);
      if (op_r == OP_IN) pole_r[idx_r] <= sat32(sh_in);
      if (op_r == OP_DELAY) delayed_r <= sat32(sh_dir);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    idx_r  <= ctl.idx;
    if (op_r == OP_AMP) w_r <= w_sat;
    if (op_r == OP_FB) acc_r <= ACC_W'(prod_r) + HALF_LSB;
    if (op_r == OP_IN) res_r <= SH_W'(sat32(sh_in));
    if (op_r == OP_DIRECT) res_r <= sh_dir;
    if (op_r == OP_AMP) begin
      p_r <= SUM_W'(delayed_r);
    end else if (res_pend_r) begin
      p_r <= p_r + SUM_W'(res_r);
    end
  end

endmodule

@@ test/pink_noise_shaping_filter_checker.sv @@
`timescale 1ns / 100ps

module pink_noise_shaping_filter_checker import pnsf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  pnsf_in_if               in_mon,
  pnsf_out_if              out_mon,
  input  logic             cfg_wr_en,
  input  logic [AMP_W-1:0] cfg_wr_data,
  output int               fail_count,
  output int               pending
);

  typedef struct {
    logic signed [OUT_W-1:0] pink;
    logic                    clipped;
  } pink_result_t;

  pink_result_t     expected_pink[$];
  logic [AMP_W-1:0] amplitude;
  int               pole_q8 [NPOLES];
  int               delay_q8;

  function automatic longint pole_feedback(int i);
    case (i)
      0:       return 130923;
      1:       return 130196;
      2:       return 127009;
      3:       return 113574;
      4:       return 72090;
      default: return -99824;
    endcase
  endfunction

  // last pole subtracts its input term
  function automatic longint pole_drive(int i);
    case (i)
      0:       return 7277;
      1:       return 9840;
      2:       return 20166;
      3:       return 40696;
      4:       return 69855;
      default: return -2215;
    endcase
  endfunction

  // nearest, ties towards +inf
  function automatic longint round_q17(longint v);
    return (v + 65536) >>> 17;
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic pink_result_t shape_sample(logic [WHITE_BITS-1:0] white);
    longint       gain;
    longint       w;
    longint       acc;
    longint       total;
    longint       q;
    pink_result_t r;
    gain  = (amplitude > AMP_ONE) ? 65536 : longint'(amplitude);
    w     = (longint'(white) * gain + 512) >>> AMP_SHIFT;
    total = 0;
    for (int i = 0; i < NPOLES; i++) begin
      acc        = pole_feedback(i) * pole_q8[i] + pole_drive(i) * w;
      pole_q8[i] = clamp32(round_q17(acc));
      total      = total + pole_q8[i];
    end
    total     = total + delay_q8 + round_q17(70281 * w);
    delay_q8  = clamp32(round_q17(15195 * w));
    q         = total / 256;
    r.clipped = 1'b0;
    if (q > 32767) begin
      q         = 32767;
      r.clipped = 1'b1;
    end else if (q < -32768) begin
      q         = -32768;
      r.clipped = 1'b1;
    end
    r.pink = q[OUT_W-1:0];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin : watch
    pink_result_t want;
    if (!rst_n) begin
      amplitude = AMP_ONE;
      for (int i = 0; i < NPOLES; i++) pole_q8[i] = 0;
      delay_q8 = 0;
      expected_pink.delete();
    end else begin
      if (cfg_wr_en) amplitude = cfg_wr_data;
      if (in_mon.valid && in_mon.ready) begin
        expected_pink.push_back(shape_sample(in_mon.white_sample));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pink.size() == 0) begin
          $display("%0t: unexpected transaction pink_sample=%0d clipped=%0b",
                   $time, out_mon.pink_sample, out_mon.clipped);
          fail_count++;
        end else begin
          want = expected_pink.pop_front();
          if (out_mon.pink_sample !== want.pink) begin
            $display("%0t: pink_sample expected %0d actual %0d",
                     $time, want.pink, out_mon.pink_sample);
            fail_count++;
          end
          if (out_mon.clipped !== want.clipped) begin
            $display("%0t: clipped expected %0b actual %0b",
                     $time, want.clipped, out_mon.clipped);
            fail_count++;
          end
        end
      end
    end
    pending = expected_pink.size();
  end

endmodule

@@ test/pink_noise_shaping_filter_tb.sv @@
`timescale 1ns / 100ps

module pink_noise_shaping_filter_tb;
  import pnsf_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int TARGET_ITEMS = 650;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [AMP_W-1:0] cfg_wr_data;
  int               fail_count;
  int               pending;
  int               sent;
  bit               no_idle;
  int               stall_left;

  pnsf_in_if  in_ch ();
  pnsf_out_if out_ch ();

  pink_noise_shaping_filter DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_ch),
    .out_chan    (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  pink_noise_shaping_filter_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [WHITE_BITS-1:0] pick_white(int mode);
    case (mode)
      0:       return WHITE_BITS'($urandom_range(0, 255));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      2:       return '0;
      default: return WHITE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [AMP_W-1:0] pick_amplitude();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return AMP_W'($urandom_range(0, 4095));
    if (r < 65) return AMP_W'($urandom_range(4096, 65535));
    if (r < 80) return AMP_ONE;
    return AMP_W'($urandom_range(65537, 131071));
  endfunction

  // valid stays high between back-to-back transactions
  task automatic push_white(logic [WHITE_BITS-1:0] white);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.white_sample <= white;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_amplitude(logic [AMP_W-1:0] amp);
    drain();
    repeat (24) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= amp;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else if (rst_n) begin
        idle_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int phase_len;
    int mode;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.white_sample = '0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    sent               = 0;
    no_idle            = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero and minimal gain
    set_amplitude('0);
    push_white('1);
    push_white('0);
    push_white(WHITE_BITS'(16384));
    set_amplitude(AMP_W'(1));
    push_white('1);
    push_white(WHITE_BITS'(1));
    // unity gain, alternating bit patterns
    set_amplitude(AMP_ONE);
    push_white('0);
    push_white(WHITE_BITS'(1));
    push_white('1);
    push_white(WHITE_BITS'(21845));
    push_white(WHITE_BITS'(10922));
    // gain above one acts as one; a full-scale run saturates
    set_amplitude(AMP_W'(65537));
    push_white('1);
    set_amplitude('1);
    repeat (4) push_white('1);

    while (sent < TARGET_ITEMS) begin
      set_amplitude(pick_amplitude());
      no_idle   = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(40, 100);
      repeat (phase_len) begin
        mode = $urandom_range(0, 9);
        push_white(pick_white(mode < 4 ? 3 : mode < 7 ? 0 : mode < 8 ? 1 : 2));
        if ($urandom_range(0, 59) == 0) drain();
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
